/* hdl/itbd_pkg.sv */
package itbd_pkg;

	localparam int MAX_SYMBOLS_DEF = 16;
	localparam int VALUE_BITS_DEF  = 32;

	localparam int RADIX_W   = 5;
	localparam int ALPHA_W   = 64;
	localparam int SYM_W     = 8;
	localparam int DIGIT_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
	localparam logic [SYM_W-1:0] PLUS_SYM  = 8'h2B;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIX      = 2'd0,
		CFG_ALPHA_LOW  = 2'd1,
		CFG_ALPHA_HIGH = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic load;
		logic go;
	} div_ctl_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIGIT_W-1:0] digit;
		logic               more;
	} div_stat_t;

	function automatic logic [SYM_W-1:0] sym_at(
		input logic [ALPHA_W-1:0] lo,
		input logic [ALPHA_W-1:0] hi,
		input logic [DIGIT_W-1:0] idx
	);
		logic [ALPHA_W-1:0] w;
		w = idx[3] ? hi : lo;
		return w[{idx[2:0], 3'b000} +: SYM_W];
	endfunction

endpackage

/* hdl/itbd_digit_div.sv */
module itbd_digit_div #(
	parameter int VALUE_BITS = itbd_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  itbd_pkg::div_ctl_t           ctl,
	input  logic [VALUE_BITS-1:0]        dividend,
	input  logic [itbd_pkg::RADIX_W-1:0] radix,
	output itbd_pkg::div_stat_t          stat
);
	import itbd_pkg::*;

	localparam int BW = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [BW-1:0]         bit_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  nz_q;
	logic [RADIX_W-1:0]    trial;
	logic [RADIX_W-1:0]    diff;
	logic                  ge;

	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge    = trial >= radix;
	assign diff  = trial - radix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			nz_q   <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= busy_q && (bit_q == '0);
			if (ctl.go) begin
				busy_q <= 1'b1;
				bit_q  <= BW'(VALUE_BITS - 1);
				nz_q   <= 1'b0;
			end else if (busy_q) begin
				nz_q  <= nz_q | ge;
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_q <= dividend;
		end else if (busy_q && !ctl.go) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
		end
		if (ctl.go) begin
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign stat.busy  = busy_q;
	assign stat.done  = done_q;
	assign stat.digit = rem_q;
	assign stat.more  = nz_q;

endmodule

/* hdl/itbd_alpha_chk.sv */
module itbd_alpha_chk #(
	parameter int MAX_SYMBOLS = itbd_pkg::MAX_SYMBOLS_DEF
) (
	input  logic [itbd_pkg::RADIX_W-1:0] radix,
	input  logic [itbd_pkg::ALPHA_W-1:0] alpha_low,
	input  logic [itbd_pkg::ALPHA_W-1:0] alpha_high,
	output logic                         ok
);
	import itbd_pkg::*;

	logic [SYM_W-1:0] syms [MAX_SYMBOLS];
	logic             bad;

	always_comb begin
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			syms[i] = sym_at(alpha_low, alpha_high, DIGIT_W'(i));
		end
	end

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if ((RADIX_W'(i) < radix) && ((syms[i] == MINUS_SYM) || (syms[i] == PLUS_SYM))) begin
				bad = 1'b1;
			end
			for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
				if ((RADIX_W'(j) < radix) && (syms[i] == syms[j])) begin
					bad = 1'b1;
				end
			end
		end
	end

	assign ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_SYMBOLS)) && !bad;

endmodule

/* hdl/integer_to_base_digits_top.sv */
// Each digit of the input value takes one bit-serial pass of the divider over the word.
// The block takes no new input transaction until it has loaded the last symbol of the previous one.
// Digits leave at one symbol per cycle from the digit stack, unless the output stalls.
// Reset clears the control state and the configuration registers; the digit stack
// is left unset and needs no clearing pass.
module integer_to_base_digits_top #(
	parameter int MAX_SYMBOLS = itbd_pkg::MAX_SYMBOLS_DEF,
	parameter int VALUE_BITS  = itbd_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [itbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [itbd_pkg::ALPHA_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [VALUE_BITS-1:0]   value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [itbd_pkg::SYM_W-1:0]     symbol,
	output logic                           last
);
	import itbd_pkg::*;

	localparam int CW = $clog2(VALUE_BITS + 1);
	localparam int AW = $clog2(VALUE_BITS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CHK  = 5'b00010,
		S_DIV  = 5'b00100,
		S_RD   = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [RADIX_W-1:0]  radix_q;
	logic [ALPHA_W-1:0]  alpha_low_q;
	logic [ALPHA_W-1:0]  alpha_high_q;
	logic                ok_c;
	logic                ok_q;
	logic                neg_q;
	logic                minus_pend_q;
	logic [CW-1:0]       cnt_q;
	logic [DIGIT_W-1:0]  stack_q [VALUE_BITS];
	logic [DIGIT_W-1:0]  rd_q;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                out_valid_q;
	logic [SYM_W-1:0]    symbol_q;
	logic                last_q;
	logic                in_acc;
	logic                out_free;
	logic                load_minus;
	logic                load_digit;
	logic [VALUE_BITS-1:0] value_u;
	logic [VALUE_BITS-1:0] mag;
	div_ctl_t            div_ctl;
	div_stat_t           div_stat;

	itbd_alpha_chk #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_chk (
		.radix      (radix_q),
		.alpha_low  (alpha_low_q),
		.alpha_high (alpha_high_q),
		.ok         (ok_c)
	);

	itbd_digit_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (mag),
		.radix    (radix_q),
		.stat     (div_stat)
	);

	assign value_u  = $unsigned(value);
	assign mag      = value_u[VALUE_BITS-1] ? VALUE_BITS'(~value_u + 1'b1) : value_u;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign load_minus = minus_pend_q && out_free;
	assign load_digit = (state_q == S_EMIT) && !minus_pend_q && out_free;

	assign div_ctl.load = in_acc;
	assign div_ctl.go   = ((state_q == S_CHK) && ok_q) ||
	                      ((state_q == S_DIV) && div_stat.done && div_stat.more);

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = AW'(cnt_q - 1'b1);
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				state_d = ok_q ? S_DIV : S_IDLE;
			end
			S_DIV: begin
				if (div_stat.done && !div_stat.more) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				rd_en   = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (load_digit) begin
					if (cnt_q == '0) begin
						state_d = S_IDLE;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			radix_q      <= '0;
			alpha_low_q  <= '0;
			alpha_high_q <= '0;
			ok_q         <= 1'b0;
			neg_q        <= 1'b0;
			minus_pend_q <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_c;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RADIX:      radix_q      <= cfg_data[RADIX_W-1:0];
					CFG_ALPHA_LOW:  alpha_low_q  <= cfg_data;
					CFG_ALPHA_HIGH: alpha_high_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				neg_q <= value_u[VALUE_BITS-1];
				cnt_q <= '0;
			end
			if ((state_q == S_CHK) && ok_q) begin
				minus_pend_q <= neg_q;
			end else if (load_minus) begin
				minus_pend_q <= 1'b0;
			end
			if ((state_q == S_DIV) && div_stat.done) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (load_minus || load_digit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DIV) && div_stat.done) begin
			stack_q[cnt_q[AW-1:0]] <= div_stat.digit;
		end
		if (rd_en) begin
			rd_q <= stack_q[rd_addr];
		end
		if (load_minus) begin
			symbol_q <= MINUS_SYM;
			last_q   <= 1'b0;
		end else if (load_digit) begin
			symbol_q <= sym_at(alpha_low_q, alpha_high_q, rd_q);
			last_q   <= (cnt_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(VALUE_BITS))
		else $error("digit count beyond stack depth");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide phase");

	a_minus_before_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && (state_d == S_IDLE)) |-> !minus_pend_q)
		else $error("number ended with its minus sign still pending");

	a_no_go_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !div_ctl.go)
		else $error("divider restarted mid-pass");

endmodule

/* bench/digit_text_checker.sv */
module digit_text_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [itbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [itbd_pkg::ALPHA_W-1:0]        cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [itbd_pkg::VALUE_BITS_DEF-1:0] value,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [itbd_pkg::SYM_W-1:0]          symbol,
	input  logic                                last,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  values_seen,
	output int                                  symbols_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import itbd_pkg::*;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} text_char_t;

	logic [RADIX_W-1:0] radix_q;
	logic [ALPHA_W-1:0] alpha_lo_q;
	logic [ALPHA_W-1:0] alpha_hi_q;
	text_char_t         expected_text[$];
	text_char_t         want;

	function automatic logic [SYM_W-1:0] glyph(input logic [DIGIT_W-1:0] idx);
		logic [ALPHA_W-1:0] word;
		word = idx[3] ? alpha_hi_q : alpha_lo_q;
		word = word >> (8 * idx[2:0]);
		return word[SYM_W-1:0];
	endfunction

	function automatic bit alphabet_usable();
		int i;
		int j;
		if (radix_q < 2 || radix_q > MAX_SYMBOLS_DEF)
			return 1'b0;
		for (i = 0; i < radix_q; i++) begin
			if (glyph(DIGIT_W'(i)) == MINUS_SYM || glyph(DIGIT_W'(i)) == PLUS_SYM)
				return 1'b0;
			for (j = i + 1; j < radix_q; j++)
				if (glyph(DIGIT_W'(j)) == glyph(DIGIT_W'(i)))
					return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic predict_text(input logic signed [VALUE_BITS_DEF-1:0] v);
		logic [VALUE_BITS_DEF-1:0] quotient;
		logic [DIGIT_W-1:0]        digits [VALUE_BITS_DEF];
		int                        count;
		int                        k;
		if (!alphabet_usable())
			return;
		if (v[VALUE_BITS_DEF-1])
			expected_text.push_back({MINUS_SYM, 1'b0});
		quotient = v[VALUE_BITS_DEF-1] ? ~v + 1'b1 : v;
		count = 0;
		do begin
			digits[count] = DIGIT_W'(quotient % radix_q);
			quotient = quotient / radix_q;
			count++;
		end while (quotient != 0);
		for (k = count - 1; k >= 0; k--)
			expected_text.push_back({glyph(digits[k]), k == 0});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q = '0;
			alpha_lo_q = '0;
			alpha_hi_q = '0;
			expected_text.delete();
			fail_count = 0;
			pending = 0;
			values_seen = 0;
			symbols_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RADIX: radix_q = cfg_data[RADIX_W-1:0];
					CFG_ALPHA_LOW: alpha_lo_q = cfg_data;
					CFG_ALPHA_HIGH: alpha_hi_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				values_seen++;
				predict_text(value);
			end
			if (out_valid && !out_stall) begin
				symbols_seen++;
				if (expected_text.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected transaction, symbol %h last %0d", $time,
						symbol, last);
				end else begin
					want = expected_text.pop_front();
					if (symbol !== want.symbol) begin
						fail_count++;
						$display("%0t: symbol expected %h actual %h", $time, want.symbol,
							symbol);
					end
					if (last !== want.last) begin
						fail_count++;
						$display("%0t: last expected %0d actual %0d", $time, want.last, last);
					end
				end
			end
			pending = expected_text.size();
		end
	end

endmodule

/* bench/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import itbd_pkg::*;

	localparam int RANDOM_ITEMS  = 195;
	localparam int SETTLE_CYCLES = 1200;
	localparam int QUIET_CYCLES  = 4;
	localparam int HOLD_CYCLES   = 700;
	localparam int TIMEOUT_NS    = 20_000_000;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam logic [ALPHA_W-1:0] DIGITS_LO    = 64'h3736_3534_3332_3130;
	localparam logic [ALPHA_W-1:0] DEC_HI       = 64'h0000_0000_0000_3938;
	localparam logic [ALPHA_W-1:0] HEX_HI       = 64'h4645_4443_4241_3938;
	localparam logic [ALPHA_W-1:0] BIN_LO       = 64'h2D2D_2D2D_2D2D_3130;
	localparam logic [ALPHA_W-1:0] BIN_HI       = 64'h2B2B_2B2B_2B2B_2B2B;
	localparam logic [ALPHA_W-1:0] NUL_LO       = 64'h2D2D_2D2D_2D62_6100;
	localparam logic [ALPHA_W-1:0] HEX_PLUS_HI  = 64'h2B45_4443_4241_3938;
	localparam logic [ALPHA_W-1:0] DEC_MINUS_LO = 64'h3736_3534_3332_312D;
	localparam logic [ALPHA_W-1:0] HEX_DUP_HI   = 64'h4645_4435_4241_3938;

	typedef enum {FLOW, LIGHT, HALF, HEAVY} stall_mode_t;
	typedef enum {BAD_LOW_RADIX, BAD_HIGH_RADIX, BAD_PLUS, BAD_MINUS, BAD_REPEAT}
		alphabet_fault_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]           cfg_index = CFG_RADIX;
	logic [ALPHA_W-1:0]             cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic signed [VALUE_BITS_DEF-1:0] value = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [SYM_W-1:0]               symbol;
	logic                           last;

	int fail_count;
	int pending;
	int values_seen;
	int symbols_seen;
	int settings_count = 0;
	bit hold_request = 1'b0;

	integer_to_base_digits_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.symbol    (symbol),
		.last      (last)
	);

	digit_text_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol       (symbol),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending),
		.values_seen  (values_seen),
		.symbols_seen (symbols_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic [RADIX_W-1:0] r, input logic [ALPHA_W-1:0] lo,
		input logic [ALPHA_W-1:0] hi);
		logic [ALPHA_W-1:0] radix_word;
		radix_word = {$urandom, $urandom};
		radix_word[RADIX_W-1:0] = r;
		write_reg(CFG_RADIX, radix_word);
		write_reg(CFG_ALPHA_LOW, lo);
		write_reg(CFG_ALPHA_HIGH, hi);
		write_reg(CFG_SPARE, {$urandom, $urandom});
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	task automatic send_value(input logic signed [VALUE_BITS_DEF-1:0] v);
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_quiet(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic signed [VALUE_BITS_DEF-1:0] pick_value();
		int                        sel;
		logic [VALUE_BITS_DEF-1:0] v;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			v = $urandom;
		end else if (sel < 6) begin
			v = $urandom_range(0, 600) - 300;
		end else if (sel < 7) begin
			case ($urandom_range(0, 4))
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = '1;
				3: v = '0;
				default: v = 32'd1;
			endcase
		end else if (sel < 8) begin
			v = 32'd1 << $urandom_range(0, 31);
			if ($urandom_range(0, 1))
				v = v - 1'b1;
			if ($urandom_range(0, 1))
				v = -v;
		end else begin
			v = $urandom >> $urandom_range(0, 31);
			if ($urandom_range(0, 1))
				v = -v;
		end
		return v;
	endfunction

	function automatic void make_alphabet(input bit force_ok, output logic [RADIX_W-1:0] r,
		output logic [ALPHA_W-1:0] lo, output logic [ALPHA_W-1:0] hi, output bit ok);
		logic [SYM_W-1:0] syms [16];
		bit               used [256];
		int               i;
		int               j;
		alphabet_fault_t  fault;
		logic [SYM_W-1:0] b;
		r = RADIX_W'($urandom_range(2, 16));
		for (i = 0; i < 256; i++)
			used[i] = 1'b0;
		used[PLUS_SYM] = 1'b1;
		used[MINUS_SYM] = 1'b1;
		for (i = 0; i < 16; i++) begin
			if (i < r) begin
				do b = SYM_W'($urandom); while (used[b]);
				used[b] = 1'b1;
				syms[i] = b;
			end else begin
				syms[i] = SYM_W'($urandom);
			end
		end
		ok = 1'b1;
		if (!force_ok && $urandom_range(0, 6) == 0) begin
			ok = 1'b0;
			fault = alphabet_fault_t'($urandom_range(0, 4));
			case (fault)
				BAD_LOW_RADIX: r = RADIX_W'($urandom_range(0, 1));
				BAD_HIGH_RADIX: r = RADIX_W'($urandom_range(17, 31));
				BAD_PLUS: syms[$urandom_range(0, r - 1)] = PLUS_SYM;
				BAD_MINUS: syms[$urandom_range(0, r - 1)] = MINUS_SYM;
				default: begin
					i = $urandom_range(0, r - 2);
					j = $urandom_range(i + 1, r - 1);
					syms[j] = syms[i];
				end
			endcase
		end
		for (i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = syms[i];
			hi[i*8 +: 8] = syms[i+8];
		end
	endfunction

	initial begin : receiver
		stall_mode_t mode;
		int          left;
		int          hold_left;
		mode = FLOW;
		left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					left = $urandom_range(20, 200);
				end
				left--;
				case (mode)
					FLOW: out_stall <= 1'b0;
					LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					HALF: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= ($urandom_range(0, 9) < 8);
				endcase
			end
		end
	end

	initial begin : stimulus
		int                   valid_items;
		int                   items_left;
		int                   gap_odds;
		logic [RADIX_W-1:0]   r;
		logic [ALPHA_W-1:0]   lo;
		logic [ALPHA_W-1:0]   hi;
		bit                   ok;
		bit                   first;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset leaves radix zero: nothing comes out
		send_value(5);
		wait_quiet(SETTLE_CYCLES);

		configure(10, DIGITS_LO, DEC_HI);
		send_value(0);
		send_value(1);
		send_value(-1);
		send_value(32'sh7FFF_FFFF);
		send_value(32'sh8000_0000);
		send_value(1234567890);
		wait_quiet(QUIET_CYCLES);

		configure(16, DIGITS_LO, HEX_HI);
		send_value(32'shFFFF_FFFF);
		send_value(32'sh7FFF_FFFF);
		send_value(32'sh8000_0000);
		send_value(32'shDEAD_BEEF);
		wait_quiet(QUIET_CYCLES);

		// signs beyond the radix are outside the alphabet
		configure(2, BIN_LO, BIN_HI);
		send_value(32'sh8000_0000);
		send_value(32'sh7FFF_FFFF);
		send_value(0);
		wait_quiet(QUIET_CYCLES);

		// zero byte used as a symbol
		configure(3, NUL_LO, '0);
		send_value(0);
		send_value(8);
		wait_quiet(QUIET_CYCLES);

		configure(1, DIGITS_LO, DEC_HI);
		send_value(7);
		wait_quiet(SETTLE_CYCLES);
		configure(17, DIGITS_LO, HEX_HI);
		send_value(-7);
		wait_quiet(SETTLE_CYCLES);
		configure(16, DIGITS_LO, HEX_PLUS_HI);
		send_value(300);
		wait_quiet(SETTLE_CYCLES);
		configure(10, DEC_MINUS_LO, DEC_HI);
		send_value(-300);
		wait_quiet(SETTLE_CYCLES);
		// repeat that does not involve symbol zero
		configure(16, DIGITS_LO, HEX_DUP_HI);
		send_value(32'sh1234_5678);
		wait_quiet(SETTLE_CYCLES);

		valid_items = 0;
		first = 1'b1;
		while (valid_items < RANDOM_ITEMS) begin
			make_alphabet(first, r, lo, hi, ok);
			configure(r, lo, hi);
			if (first)
				hold_request = 1'b1;
			first = 1'b0;
			items_left = ok ? $urandom_range(8, 30) : $urandom_range(2, 5);
			gap_odds = $urandom_range(0, 4);
			repeat (items_left) begin
				send_value(pick_value());
				if (ok)
					valid_items++;
				if (gap_odds != 0 && $urandom_range(1, gap_odds * 2) == 1)
					pause($urandom_range(1, 24));
			end
			wait_quiet(ok ? QUIET_CYCLES : SETTLE_CYCLES);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Converted %0d values under %0d alphabet settings, valid and invalid,",
			values_seen, settings_count);
		$display("with a long output hold; %0d symbols compared.", symbols_seen);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
hdl/itbd_pkg.sv
hdl/itbd_digit_div.sv
hdl/itbd_alpha_chk.sv
hdl/integer_to_base_digits_top.sv
bench/digit_text_checker.sv
bench/testbench.sv
